@@ rtl/core/arll_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the auto-ranging light level block.
// No dependencies; used by arll_ctrl, arll_dp and auto_ranging_light_level.
package arll_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CEIL_W   = 4;
  localparam int SUM_W    = 14;
  localparam int LOW_W    = 11;
  localparam int REM_W    = 14;
  localparam int DIV_STEPS = 4;
  localparam int STEP_W    = 2;

  localparam logic [SUM_W-1:0]    SUM_RESET  = 14'd5940;
  localparam logic [LOW_W-1:0]    LOW_RESET  = 11'd1024;
  localparam logic [CEIL_W-1:0]   CEIL_RESET = 4'd4;

  // floor(x / 10) == (x * 6554) >> 16 for every x below 10240
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef struct packed {
    logic              load;
    logic              calc;
    logic              update;
    logic              prep;
    logic              div_en;
    logic [STEP_W-1:0] div_idx;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic span_zero;
    logic out_stall;
  } dp_sts_t;

endpackage

@@ rtl/core/arll_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the auto-ranging light level block.
// Depends on arll_pkg; drives arll_dp through command and status structs.
module arll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output arll_pkg::dp_cmd_t cmd,
  input  arll_pkg::dp_sts_t sts
);
  import arll_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPD,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] idx_r, idx_nxt;
  logic              in_beat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_CALC;
      end
      ST_CALC: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_PREP;
      ST_PREP: begin
        idx_nxt   = STEP_W'(DIV_STEPS - 1);
        state_nxt = sts.span_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (idx_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts.out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = in_beat;
    cmd.calc     = (state_r == ST_CALC);
    cmd.update   = (state_r == ST_UPD);
    cmd.prep     = (state_r == ST_PREP);
    cmd.div_en   = (state_r == ST_DIV);
    cmd.div_idx  = idx_r;
    cmd.out_load = (state_r == ST_DONE) && !sts.out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r == ST_CALC)
    else $error("accepted beat did not start work");
  a_div_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !sts.span_zero)
    else $error("division entered with empty range");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_stall)
    else $error("output loaded while stalled");
`endif

endmodule

@@ rtl/core/arll_dp.sv @@
`timescale 1ns / 1ps
// Datapath: leaky sum, divide by ten, min/max tracking, shift-subtract scaling.
// Depends on arll_pkg; sequenced by arll_ctrl.
module arll_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [arll_pkg::SAMPLE_W-1:0] sample,
  input  logic                          cfg_wr_en,
  input  logic [arll_pkg::CEIL_W-1:0]   cfg_wr_data,
  input  arll_pkg::dp_cmd_t             cmd,
  output arll_pkg::dp_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [arll_pkg::CEIL_W-1:0]   out_scaled,
  output logic [arll_pkg::SAMPLE_W-1:0] out_smoothed
);
  import arll_pkg::*;

  logic [CEIL_W-1:0]   ceil_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    total_r;
  logic [SAMPLE_W-1:0] level_r;
  logic [LOW_W-1:0]    low_r;
  logic [SAMPLE_W-1:0] high_r;
  logic [REM_W-1:0]    rem_r;
  logic [SAMPLE_W-1:0] span_r;
  logic [CEIL_W-1:0]   quot_r;
  logic                out_valid_r;
  logic [CEIL_W-1:0]   out_scaled_r;
  logic [SAMPLE_W-1:0] out_smoothed_r;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] low10;
  logic [SAMPLE_W-1:0] span_nxt;
  logic [REM_W-1:0]    trial;

  assign prod     = PROD_W'(total_r) * PROD_W'(RECIP_TEN);
  assign low10    = low_r[SAMPLE_W-1:0];
  assign span_nxt = high_r - low10;
  assign trial    = REM_W'(span_r) << cmd.div_idx;

  assign sts.span_zero = (span_nxt == '0);
  assign sts.out_stall = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_scaled   = out_scaled_r;
  assign out_smoothed = out_smoothed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r      <= CEIL_RESET;
      sum_r       <= SUM_RESET;
      low_r       <= LOW_RESET;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) ceil_r <= cfg_wr_data;
      if (cmd.update) begin
        sum_r <= total_r - SUM_W'(level_r);
        if (LOW_W'(level_r) < low_r) low_r <= LOW_W'(level_r);
        if (level_r > high_r) high_r <= level_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) total_r <= sum_r + SUM_W'(sample);
    if (cmd.calc) level_r <= prod[RECIP_SHIFT +: SAMPLE_W];
    if (cmd.prep) begin
      rem_r  <= REM_W'(level_r - low10) * REM_W'(ceil_r);
      span_r <= span_nxt;
      quot_r <= '0;
    end
    if (cmd.div_en && (rem_r >= trial)) begin
      rem_r                <= rem_r - trial;
      quot_r[cmd.div_idx]  <= 1'b1;
    end
    if (cmd.out_load) begin
      out_scaled_r   <= quot_r;
      out_smoothed_r <= level_r;
    end
  end

`ifndef SYNTH
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    !low_r[LOW_W-1] |-> low10 <= high_r)
    else $error("lowest seen above highest seen");
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> quot_r <= ceil_r)
    else $error("scaled level above ceiling");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result not presented after load");
`endif

endmodule

@@ rtl/core/auto_ranging_light_level.sv @@
`timescale 1ns / 1ps
// Auto-ranging light level: leaky average of sensor samples scaled onto 0..ceiling.
// Each beat: calc, update, prep, 4-step divide (skipped with an empty range), done.
// No new beat is taken until the block is back in idle; done waits on a stalled output.
// Output register lets the next beat start while a result waits to be taken.
// Reset (rst_n, synchronous): sum 5940, range empty, ceiling 4, no result pending.
module auto_ranging_light_level (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] sensor_sample, [15:10] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] scaled_level, [13:4] smoothed_level, [15:14] zero
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data // [3:0] brightness_ceiling
);
  import arll_pkg::*;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [CEIL_W-1:0]   scaled;
  logic [SAMPLE_W-1:0] smoothed;

  arll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  arll_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample       (in_tdata[SAMPLE_W-1:0]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_scaled   (scaled),
    .out_smoothed (smoothed)
  );

  assign out_tdata = {2'b00, smoothed, scaled};

endmodule

@@ dv/light_level_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for auto_ranging_light_level: tracks the leaky sum and the seen range,
// predicts every result beat and compares it field by field. Depends on arll_pkg.
module light_level_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  output int          mismatches,
  output int          pending
);
  import arll_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CEIL_W-1:0]   scaled;
    logic [SAMPLE_W-1:0] smoothed;
  } level_beat_t;

  logic [SUM_W-1:0]    leaky_sum;
  logic [LOW_W-1:0]    lowest_seen;
  logic [SAMPLE_W-1:0] highest_seen;
  logic [CEIL_W-1:0]   ceiling;
  level_beat_t         expected_levels[$];

  function automatic level_beat_t predict_level(input logic [SAMPLE_W-1:0] sample);
    int unsigned total;
    int unsigned level;
    level_beat_t beat;
    total = leaky_sum + sample;
    level = total / 10;
    leaky_sum = SUM_W'(total - level);
    level = level & 32'h3FF;
    if (level < lowest_seen) lowest_seen = LOW_W'(level);
    if (level > highest_seen) highest_seen = SAMPLE_W'(level);
    beat.smoothed = SAMPLE_W'(level);
    beat.scaled = '0;
    if (highest_seen > lowest_seen && level >= lowest_seen) begin
      beat.scaled = CEIL_W'(((level - lowest_seen) * ceiling) / (highest_seen - lowest_seen));
    end
    return beat;
  endfunction

  task automatic log_mismatch(input string what, input int want, input int got);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    level_beat_t want;
    logic in_beat;
    logic out_beat;
    in_beat = in_tvalid && in_tready;
    out_beat = out_tvalid && out_tready;
    if (!rst_n) begin
      leaky_sum = SUM_RESET;
      lowest_seen = LOW_RESET;
      highest_seen = '0;
      ceiling = CEIL_RESET;
      expected_levels.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) ceiling = cfg_wr_data;
      if (in_beat) expected_levels.push_back(predict_level(in_tdata[SAMPLE_W-1:0]));
      if (out_beat) begin
        if (expected_levels.size() == 0) begin
          log_mismatch("unexpected beat, out_tdata", 0, int'(out_tdata));
        end else begin
          want = expected_levels.pop_front();
          if (out_tdata[3:0] != want.scaled) begin
            log_mismatch("scaled_level", int'(want.scaled), int'(out_tdata[3:0]));
          end
          if (out_tdata[13:4] != want.smoothed) begin
            log_mismatch("smoothed_level", int'(want.smoothed), int'(out_tdata[13:4]));
          end
        end
      end
      pending <= pending + int'(in_beat) - int'(out_beat);
    end
  end

endmodule

@@ dv/auto_ranging_light_level_test.sv @@
`timescale 1ns / 1ps
// Top of the auto_ranging_light_level regression: clock, reset, sample and
// ceiling stimulus, output back-pressure and verdict. Needs arll_pkg and light_level_checker.
module auto_ranging_light_level_test;
  import arll_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 225;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [10] = '{
    10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023,
    10'd512, 10'h2AA, 10'h155, 10'd0, 10'd1023
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  logic        hold_start = 1'b0;
  int          hold_left = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          cycles = 0;
  int          mismatches;
  int          pending;
  logic [SAMPLE_W-1:0] last_sample = '0;

  auto_ranging_light_level dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  light_level_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("auto_ranging_light_level regression: fail");
      $finish;
    end
  end

  // hold off the output for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_tready <= !hold_start && hold_left == 0 && $urandom_range(0, 99) >= out_stall_pct;
  end

  function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] prev);
    int pick;
    int walk;
    pick = $urandom_range(0, 99);
    if (pick < 40) return SAMPLE_W'($urandom_range(0, 1023));
    if (pick < 70) begin
      walk = int'(prev) + int'($urandom_range(0, 64)) - 32;
      if (walk < 0) walk = 0;
      if (walk > 1023) walk = 1023;
      return SAMPLE_W'(walk);
    end
    if (pick < 85) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    return prev;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 16'($urandom_range(0, 1023));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, sample};
    last_sample = sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_ceiling(input logic [3:0] ceiling);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ceiling;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [3:0] ceiling;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i]);
    drain();
    set_ceiling(4'd15);
    for (int i = 0; i < 6; i++) send_sample(CORNER_SAMPLES[i]);
    drain();
    set_ceiling(4'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    drain();
    set_ceiling(4'd15);

    // fill the block while the output is held off
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (12) send_sample(next_sample(last_sample));
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct = 0;
          out_stall_pct <= 0;
          ceiling = 4'($urandom_range(1, 14));
        end
        1: begin
          in_idle_pct = 72;
          out_stall_pct <= 0;
          ceiling = 4'd15;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct <= 72;
          ceiling = 4'($urandom_range(0, 15));
        end
        default: begin
          in_idle_pct = 29;
          out_stall_pct <= 29;
          ceiling = 4'd0;
        end
      endcase
      set_ceiling(ceiling);
      repeat (PHASE_ITEMS) send_sample(next_sample(last_sample));
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("auto_ranging_light_level regression: pass");
    end else begin
      $display("auto_ranging_light_level regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/arll_pkg.sv
rtl/core/arll_ctrl.sv
rtl/core/arll_dp.sv
rtl/core/auto_ranging_light_level.sv
dv/light_level_checker.sv
dv/auto_ranging_light_level_test.sv
